// File: rtl/min_cost_set_cover_dp_top_assert.svh
// ----------------------------------------------------------------------------
// min_cost_set_cover_dp_top_assert
// Assertion macros for the set cover RTL.
// ----------------------------------------------------------------------------
`ifndef MIN_COST_SET_COVER_DP_TOP_ASSERT_SVH
`define MIN_COST_SET_COVER_DP_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MCSC_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled during reset
`define MCSC_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication check failed");

`endif

// File: rtl/mcsc_pkg.sv
// ----------------------------------------------------------------------------
// mcsc_pkg
// Widths, types and helpers for the min-cost set cover DP block.
// ----------------------------------------------------------------------------
package mcsc_pkg;

    localparam int MAX_ELEMENTS = 12;
    localparam int COST_WIDTH   = 48;
    localparam int TABLE_DEPTH  = 1 << MAX_ELEMENTS;
    localparam int IDX_W        = MAX_ELEMENTS;
    localparam int OFFER_COST_W = 32;
    localparam int MASK_W       = 12;
    localparam int BEST_COST_W  = 48;
    localparam int NUM_W        = 4;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [COST_WIDTH-1:0]   t_cost;
    typedef logic [COST_WIDTH:0]     t_sum;
    typedef logic [OFFER_COST_W-1:0] t_offer_cost;
    typedef logic [MASK_W-1:0]       t_mask;
    typedef logic [BEST_COST_W-1:0]  t_best;
    typedef logic [NUM_W-1:0]        t_num;
    typedef logic [APB_ADDR_W-1:0]   t_paddr;
    typedef logic [APB_DATA_W-1:0]   t_pdata;

    localparam t_num  NUM_RESET  = t_num'(12);
    localparam t_cost COST_LIMIT = '1;

    // Register index, taken from the word address
    typedef enum logic [APB_ADDR_W-3:0] {
        REG_NUM_ELEMENTS = 1'b0
    } t_reg_idx;

    // One table entry
    typedef struct packed {
        logic  valid;
        t_cost cost;
    } t_entry;

    // One table write
    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry data;
    } t_wr;

    // Full-set mask for an element count, count clamped to 1..MAX_ELEMENTS
    function automatic t_idx full_set(input t_num num);
        int   n;
        t_idx f;
        n = int'(num);
        if (n < 1) n = 1;
        if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
        f = '0;
        for (int i = 0; i < IDX_W; i++) begin
            if (i < n) f[i] = 1'b1;
        end
        return f;
    endfunction

endpackage

// File: rtl/mcsc_offer_if.sv
// ----------------------------------------------------------------------------
// mcsc_offer_if
// Valid/ready channel carrying one offer (cost, cover mask, last flag).
// ----------------------------------------------------------------------------
interface mcsc_offer_if;
    logic                      valid;
    logic                      ready;
    mcsc_pkg::t_offer_cost     offer_cost;
    mcsc_pkg::t_mask           cover_mask;
    logic                      last_offer;

    modport source (output valid, offer_cost, cover_mask, last_offer, input ready);
    modport sink   (input valid, offer_cost, cover_mask, last_offer, output ready);
endinterface

// File: rtl/mcsc_result_if.sv
// ----------------------------------------------------------------------------
// mcsc_result_if
// Valid/ready channel carrying one cover result.
// ----------------------------------------------------------------------------
interface mcsc_result_if;
    logic              valid;
    logic              ready;
    mcsc_pkg::t_best   best_cost;
    logic              reachable;
    logic              saturated;

    modport source (output valid, best_cost, reachable, saturated, input ready);
    modport sink   (input valid, best_cost, reachable, saturated, output ready);
endinterface

// File: rtl/min_cost_set_cover_dp_top.sv
// An offer is swept through the table one entry per cycle, then drained, before ready rises.
// The last offer of a set then reads the full-set entry and returns its result, and a table
// clear runs before the next offer is taken.
// Offers do not overlap: the single relax unit and table write port serve one offer at a time.
// Reset: synchronous active-low i_rst_n starts a table clearing pass; no offer is taken
// until it ends. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// min_cost_set_cover_dp_top
// Minimum-cost set cover by DP over subsets: each offer sweeps the subset
// table through one shared relax unit; the last offer returns the cover cost.
// ----------------------------------------------------------------------------
`include "min_cost_set_cover_dp_top_assert.svh"

module min_cost_set_cover_dp_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mcsc_offer_if.sink           i_offer,
    mcsc_result_if.source        o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  mcsc_pkg::t_paddr     paddr,
    input  mcsc_pkg::t_pdata     pwdata,
    output mcsc_pkg::t_pdata     prdata,
    output logic                 pready
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SWEEP  = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_RDFULL = 6'b010000,
        ST_RESULT = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    mcsc_pkg::t_idx        r_idx, n_idx;
    mcsc_pkg::t_offer_cost r_cost;
    mcsc_pkg::t_idx        r_mask;
    mcsc_pkg::t_idx        r_full;
    logic                  r_last;
    logic                  r_s1_vld, n_s1_vld;
    mcsc_pkg::t_idx        r_s1_src;
    mcsc_pkg::t_idx        r_s1_dst;
    logic                  r_out_vld, n_out_vld;
    mcsc_pkg::t_best       r_out_best;
    logic                  r_out_reach;
    logic                  r_out_sat;

    mcsc_pkg::t_num        num_elements;
    mcsc_pkg::t_wr         upd_wr;
    mcsc_pkg::t_wr         ram_wr;
    logic                  rd_en;
    mcsc_pkg::t_idx        rd_addr_a;
    mcsc_pkg::t_idx        rd_addr_b;
    mcsc_pkg::t_entry      rd_data_a;
    mcsc_pkg::t_entry      rd_data_b;
    logic                  in_xfer;
    logic                  out_load;

    mcsc_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_num_elements (num_elements)
    );

    mcsc_ram u_ram (
        .i_clk       (i_clk),
        .i_wr        (ram_wr),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    mcsc_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_active    (r_s1_vld),
        .i_src_addr  (r_s1_src),
        .i_dst_addr  (r_s1_dst),
        .i_src_entry (rd_data_a),
        .i_dst_entry (rd_data_b),
        .i_cost      (r_cost),
        .o_wr        (upd_wr)
    );

    assign i_offer.ready = (r_state == ST_IDLE);
    assign in_xfer       = i_offer.valid && i_offer.ready;
    assign out_load      = (r_state == ST_RESULT) && (!r_out_vld || o_result.ready);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_s1_vld  = 1'b0;
        n_out_vld = r_out_vld;
        rd_en     = 1'b0;
        rd_addr_a = r_idx;
        rd_addr_b = r_idx | r_mask;
        ram_wr    = upd_wr;

        if (r_out_vld && o_result.ready) n_out_vld = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                ram_wr.en         = 1'b1;
                ram_wr.addr       = r_idx;
                ram_wr.data.valid = (r_idx == '0);
                ram_wr.data.cost  = '0;
                n_idx             = r_idx + 1'b1;
                if (r_idx == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                n_idx = '0;
                if (in_xfer) n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                rd_en    = 1'b1;
                n_s1_vld = 1'b1;
                n_idx    = r_idx + 1'b1;
                if (r_idx == '1) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = r_last ? ST_RDFULL : ST_IDLE;
            end
            ST_RDFULL: begin
                rd_en     = 1'b1;
                rd_addr_a = r_full;
                n_state   = ST_RESULT;
            end
            ST_RESULT: begin
                n_idx = '0;
                if (out_load) begin
                    n_out_vld = 1'b1;
                    n_state   = ST_CLEAR;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Capture the offer; mask bits beyond the element count drop out
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cost <= i_offer.offer_cost;
            r_mask <= mcsc_pkg::t_idx'(i_offer.cover_mask)
                      & mcsc_pkg::full_set(num_elements);
            r_full <= mcsc_pkg::full_set(num_elements);
            r_last <= i_offer.last_offer;
        end
    end

    // Advance the read addresses into the relax stage
    always_ff @(posedge i_clk) begin
        r_s1_src <= rd_addr_a;
        r_s1_dst <= rd_addr_b;
    end

    // Load the result from the full-set entry
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_reach <= rd_data_a.valid;
            r_out_best  <= rd_data_a.valid ? mcsc_pkg::t_best'(rd_data_a.cost) : '0;
            r_out_sat   <= rd_data_a.valid && (rd_data_a.cost == mcsc_pkg::COST_LIMIT);
        end
    end

    assign o_result.valid     = r_out_vld;
    assign o_result.best_cost = r_out_best;
    assign o_result.reachable = r_out_reach;
    assign o_result.saturated = r_out_sat;

    // Checks
    `MCSC_ASSERT_IMP(a_ready_pipe_empty, i_clk, i_rst_n, i_offer.ready,
                     !r_s1_vld && !upd_wr.en)
    `MCSC_ASSERT_IMP(a_write_superset, i_clk, i_rst_n, upd_wr.en,
                     (upd_wr.addr | r_mask) == upd_wr.addr)
    `MCSC_ASSERT_IMP(a_no_relax_in_clear, i_clk, i_rst_n, r_state == ST_CLEAR,
                     !upd_wr.en && !r_s1_vld)
    `MCSC_ASSERT_IMP(a_result_from_read, i_clk, i_rst_n, $rose(r_out_vld),
                     $past(r_state == ST_RESULT))
    `MCSC_ASSERT_NXT(a_clear_ends_idle, i_clk, i_rst_n,
                     r_state == ST_CLEAR && r_idx == '1, r_state == ST_IDLE)

endmodule

// File: rtl/mcsc_regs.sv
// ----------------------------------------------------------------------------
// mcsc_regs
// APB configuration register file holding the element count.
// ----------------------------------------------------------------------------
module mcsc_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  mcsc_pkg::t_paddr  paddr,
    input  mcsc_pkg::t_pdata  pwdata,
    output mcsc_pkg::t_pdata  prdata,
    output logic              pready,
    output mcsc_pkg::t_num    o_num_elements
);

    mcsc_pkg::t_num   r_num;
    mcsc_pkg::t_reg_idx reg_idx;
    logic             wr_xfer;

    // Decode the word address and the write transfer
    assign reg_idx = mcsc_pkg::t_reg_idx'(paddr[mcsc_pkg::APB_ADDR_W-1:2]);
    assign wr_xfer = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Hold the element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= mcsc_pkg::NUM_RESET;
        end else if (wr_xfer && reg_idx == mcsc_pkg::REG_NUM_ELEMENTS) begin
            r_num <= pwdata[mcsc_pkg::NUM_W-1:0];
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            mcsc_pkg::REG_NUM_ELEMENTS: prdata = mcsc_pkg::t_pdata'(r_num);
            default:                    prdata = '0;
        endcase
    end

    assign o_num_elements = r_num;

endmodule

// File: rtl/mcsc_ram.sv
// ----------------------------------------------------------------------------
// mcsc_ram
// Subset table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mcsc_ram (
    input  logic             i_clk,
    input  mcsc_pkg::t_wr    i_wr,
    input  logic             i_rd_en,
    input  mcsc_pkg::t_idx   i_rd_addr_a,
    input  mcsc_pkg::t_idx   i_rd_addr_b,
    output mcsc_pkg::t_entry o_rd_data_a,
    output mcsc_pkg::t_entry o_rd_data_b
);

    mcsc_pkg::t_entry r_mem [mcsc_pkg::TABLE_DEPTH];
    mcsc_pkg::t_entry r_rd_a;
    mcsc_pkg::t_entry r_rd_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read ports, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// File: rtl/mcsc_update.sv
// ----------------------------------------------------------------------------
// mcsc_update
// Shared relax unit: saturating add of the offer cost to the source entry,
// compare against the target entry, and forwarding of the previous write.
// ----------------------------------------------------------------------------
module mcsc_update (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_active,
    input  mcsc_pkg::t_idx        i_src_addr,
    input  mcsc_pkg::t_idx        i_dst_addr,
    input  mcsc_pkg::t_entry      i_src_entry,
    input  mcsc_pkg::t_entry      i_dst_entry,
    input  mcsc_pkg::t_offer_cost i_cost,
    output mcsc_pkg::t_wr         o_wr
);

    mcsc_pkg::t_wr    r_last;
    mcsc_pkg::t_entry src;
    mcsc_pkg::t_entry dst;
    mcsc_pkg::t_sum   sum;
    mcsc_pkg::t_cost  cand;

    always_comb begin
        // Take the write of the previous cycle over stale read data
        src = i_src_entry;
        dst = i_dst_entry;
        if (r_last.en && r_last.addr == i_src_addr) src = r_last.data;
        if (r_last.en && r_last.addr == i_dst_addr) dst = r_last.data;

        // Saturating add: a carry out means past the limit
        sum  = mcsc_pkg::t_sum'(src.cost) + mcsc_pkg::t_sum'(i_cost);
        cand = sum[mcsc_pkg::COST_WIDTH] ? mcsc_pkg::COST_LIMIT
                                         : sum[mcsc_pkg::COST_WIDTH-1:0];

        // Keep the cheaper cost at the target subset
        o_wr.en         = i_active && src.valid && (!dst.valid || cand < dst.cost);
        o_wr.addr       = i_dst_addr;
        o_wr.data.valid = 1'b1;
        o_wr.data.cost  = cand;
    end

    // Register the last write for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last.en <= 1'b0;
        end else begin
            r_last <= o_wr;
        end
    end

endmodule
